// ===== rtl/core/katm_pkg.sv =====
// ----------------------------------------------------------------------------
// katm_pkg
// Types, constants and helpers shared by the knob average threshold mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package katm_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W     = 12;
    localparam int unsigned SAMPLE_SHIFT = 4;
    localparam int unsigned VAL_W        = 8;
    localparam int unsigned CUTOFF_W     = 16;
    localparam int unsigned LIMIT_W      = 17;
    localparam int unsigned DEADBAND_W   = 8;
    localparam int unsigned TICKS_W      = 16;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_VALUE_W  = 17;

    localparam int unsigned RING_DEPTH_DEFAULT = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_END_CUTOFF  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DISP_TICKS  = 3'd4;

    // Register reset values
    localparam logic [CUTOFF_W-1:0]   END_CUTOFF_RESET = 16'd6554;
    localparam logic [LIMIT_W-1:0]    LOW_LIMIT_RESET  = 17'd3277;
    localparam logic [LIMIT_W-1:0]    HIGH_LIMIT_RESET = 17'd62259;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET   = 8'd8;
    localparam logic [TICKS_W-1:0]    DISP_TICKS_RESET = 16'd500;

    // Threshold mapping: span = 1.0 + 2 * cutoff, then avg * span / 255 - cutoff
    localparam int unsigned SPAN_W     = 18;
    localparam logic [SPAN_W-1:0] SPAN_BASE = 18'd65536;
    localparam int unsigned MAP_PROD_W = VAL_W + SPAN_W;
    localparam int unsigned QUOT_W     = 18;
    localparam int unsigned THR_CALC_W = LIMIT_W + 2;

    // x / 255 for x < 2^26 as (x * ceil(2^34 / 255)) >> 34
    localparam int unsigned DIV255_MUL_W  = 27;
    localparam int unsigned DIV255_SHIFT  = 34;
    localparam logic [DIV255_MUL_W-1:0] DIV255_MUL = 27'd67372037;
    localparam int unsigned DIV_PROD_W    = MAP_PROD_W + DIV255_MUL_W;

    // Register stages from accept to result register
    localparam int unsigned PIPE_STAGES = 6;

    function automatic int unsigned total_width(input int unsigned depth);
        return $clog2(255 * depth + 1);
    endfunction

    function automatic int unsigned addr_width(input int unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    typedef struct packed {
        logic [SAMPLE_W-1:0] knob_sample;
        logic                force_update;
    } sample_t;

    typedef struct packed {
        logic [VAL_W-1:0]   held_average;
        logic [LIMIT_W-1:0] threshold_value;
        logic               updated;
        logic               display_active;
    } result_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_VALUE_W-1:0] reg_value;
    } cfg_write_t;

    typedef struct packed {
        logic [CUTOFF_W-1:0]   end_cutoff;
        logic [LIMIT_W-1:0]    low_limit;
        logic [LIMIT_W-1:0]    high_limit;
        logic [DEADBAND_W-1:0] deadband;
        logic [TICKS_W-1:0]    disp_ticks;
    } cfg_regs_t;

    typedef struct packed {
        logic [VAL_W-1:0] avg;
        logic             refresh;
        logic             active;
    } mean_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/katm_stream_if.sv =====
// ----------------------------------------------------------------------------
// katm_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface katm_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/katm_ram.sv =====
// ----------------------------------------------------------------------------
// katm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module katm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [katm_pkg::addr_width(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [katm_pkg::addr_width(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/katm_ring.sv =====
// ----------------------------------------------------------------------------
// katm_ring
// Ring of recent reduced samples with a running total; first pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module katm_ring #(
    parameter int unsigned RING_DEPTH = katm_pkg::RING_DEPTH_DEFAULT,
    parameter int unsigned TOTAL_W    = katm_pkg::total_width(RING_DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire katm_pkg::sample_t     in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [TOTAL_W-1:0]         out_total,
    output logic                       out_force
);

    localparam int unsigned PW    = katm_pkg::addr_width(RING_DEPTH);
    localparam int unsigned VAL_W = katm_pkg::VAL_W;

    logic [PW-1:0]      pos_reg, pos_next, pos_adv, rd_addr;
    logic               wrapped_reg, wrapped_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               valid_reg, valid_next;
    logic               force_reg;
    logic               byp_valid_reg, byp_valid_next;
    logic [VAL_W-1:0]   byp_data_reg;
    logic [VAL_W-1:0]   rd_data, old_val, new_val;
    logic               load, last;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign new_val  = in_data.knob_sample[katm_pkg::SAMPLE_SHIFT +: VAL_W];

    assign last    = (pos_reg == PW'(RING_DEPTH - 1));
    assign pos_adv = last ? '0 : pos_reg + PW'(1);
    // Read ahead so the entry at the write pointer is ready for the next item
    assign rd_addr = load ? pos_adv : pos_reg;

    // Entries are unwritten until the pointer first wraps; they read as zero
    always_comb
    begin
        if (!wrapped_reg)
        begin
            old_val = '0;
        end
        else if (byp_valid_reg)
        begin
            old_val = byp_data_reg;
        end
        else
        begin
            old_val = rd_data;
        end
    end

    always_comb
    begin
        total_next     = total_reg;
        pos_next       = pos_reg;
        wrapped_next   = wrapped_reg;
        byp_valid_next = load && (pos_adv == pos_reg);
        valid_next     = valid_reg && !out_ready;
        if (load)
        begin
            total_next   = total_reg - TOTAL_W'(old_val) + TOTAL_W'(new_val);
            pos_next     = pos_adv;
            wrapped_next = wrapped_reg || last;
            valid_next   = 1'b1;
        end
    end

    katm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (load),
        .waddr (pos_reg),
        .wdata (new_val),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            total_reg     <= '0;
            valid_reg     <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            wrapped_reg   <= wrapped_next;
            total_reg     <= total_next;
            valid_reg     <= valid_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            force_reg    <= in_data.force_update;
            byp_data_reg <= new_val;
        end
    end

    assign out_valid = valid_reg;
    assign out_total = total_reg;
    assign out_force = force_reg;

endmodule

`default_nettype wire

// ===== rtl/core/katm_refresh.sv =====
// ----------------------------------------------------------------------------
// katm_refresh
// Ring mean by reciprocal multiply, deadband test, held average, countdown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module katm_refresh #(
    parameter int unsigned RING_DEPTH = katm_pkg::RING_DEPTH_DEFAULT,
    parameter int unsigned TOTAL_W    = katm_pkg::total_width(RING_DEPTH)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [katm_pkg::DEADBAND_W-1:0]   deadband,
    input  wire logic [katm_pkg::TICKS_W-1:0]      disp_ticks,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [TOTAL_W-1:0]                in_total,
    input  wire logic                              in_force,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output katm_pkg::mean_item_t                   out_data
);

    localparam int unsigned VAL_W      = katm_pkg::VAL_W;
    localparam int unsigned TICKS_W    = katm_pkg::TICKS_W;
    localparam int unsigned LOG_D      = $clog2(RING_DEPTH);
    localparam int unsigned MUL_W      = TOTAL_W + 1;
    localparam int unsigned PROD_W     = TOTAL_W + MUL_W;
    localparam int unsigned MEAN_SHIFT = TOTAL_W + LOG_D;
    localparam longint unsigned MEAN_MUL_VAL =
        ((64'd1 << MEAN_SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
    localparam logic [MUL_W-1:0] MEAN_MUL = MUL_W'(MEAN_MUL_VAL);

    // Stage 2: total times reciprocal of the depth
    logic              s2_valid_reg, s2_valid_next, s2_ready, load2;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              force_reg;

    // Stage 3: mean, deadband test, state update
    logic                 s3_valid_reg, s3_valid_next, s3_ready, load3;
    logic [VAL_W-1:0]     stable_reg, stable_next;
    logic [TICKS_W-1:0]   count_reg, count_next, count_base;
    logic [VAL_W-1:0]     mean, diff;
    logic                 refresh, active;
    katm_pkg::mean_item_t item_reg, item_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = s2_ready;
    assign load2    = in_valid && s2_ready;
    assign load3    = s2_valid_reg && s3_ready;

    assign s2_valid_next = load2 || (s2_valid_reg && !s3_ready);
    assign s3_valid_next = load3 || (s3_valid_reg && !out_ready);

    assign prod_next = PROD_W'(in_total) * PROD_W'(MEAN_MUL);

    always_comb
    begin
        mean       = prod_reg[MEAN_SHIFT +: VAL_W];
        diff       = (mean > stable_reg) ? mean - stable_reg : stable_reg - mean;
        refresh    = force_reg || (diff > deadband);
        stable_next = refresh ? mean : stable_reg;
        count_base = refresh ? disp_ticks : count_reg;
        active     = (count_base != '0);
        count_next = active ? count_base - TICKS_W'(1) : count_base;
        item_next.avg     = stable_next;
        item_next.refresh = refresh;
        item_next.active  = active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            stable_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            if (load3)
            begin
                stable_reg <= stable_next;
                count_reg  <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            prod_reg  <= prod_next;
            force_reg <= in_force;
        end
        if (load3)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/katm_mapper.sv =====
// ----------------------------------------------------------------------------
// katm_mapper
// Affine map of the held average to a threshold, clamp, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module katm_mapper (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [katm_pkg::CUTOFF_W-1:0]   end_cutoff,
    input  wire logic [katm_pkg::LIMIT_W-1:0]    low_limit,
    input  wire logic [katm_pkg::LIMIT_W-1:0]    high_limit,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire katm_pkg::mean_item_t            in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output katm_pkg::result_t                    out_data
);

    localparam int unsigned SPAN_W     = katm_pkg::SPAN_W;
    localparam int unsigned MAP_PROD_W = katm_pkg::MAP_PROD_W;
    localparam int unsigned DIV_PROD_W = katm_pkg::DIV_PROD_W;
    localparam int unsigned QUOT_W     = katm_pkg::QUOT_W;
    localparam int unsigned LIMIT_W    = katm_pkg::LIMIT_W;
    localparam int unsigned CALC_W     = katm_pkg::THR_CALC_W;

    // Stage 4: avg * span
    logic                   s4_valid_reg, s4_valid_next, s4_ready, load4;
    logic [SPAN_W-1:0]      span;
    logic [MAP_PROD_W-1:0]  map_reg, map_next;
    katm_pkg::mean_item_t   item4_reg;

    // Stage 5: divide by 255 through the reciprocal
    logic                   s5_valid_reg, s5_valid_next, s5_ready, load5;
    logic [DIV_PROD_W-1:0]  div_prod;
    logic [QUOT_W-1:0]      quot_reg;
    katm_pkg::mean_item_t   item5_reg;

    // Stage 6: offset, clamp, result
    logic                   s6_valid_reg, s6_valid_next, s6_ready, load6;
    logic signed [CALC_W-1:0] thr_raw, thr_hi, thr_lo, high_s, low_s;
    logic [LIMIT_W-1:0]     thr_reg, thr_next;
    katm_pkg::result_t      result_reg, result_next;

    assign s6_ready = !s6_valid_reg || out_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;
    assign load4    = in_valid && s4_ready;
    assign load5    = s4_valid_reg && s5_ready;
    assign load6    = s5_valid_reg && s6_ready;

    assign s4_valid_next = load4 || (s4_valid_reg && !s5_ready);
    assign s5_valid_next = load5 || (s5_valid_reg && !s6_ready);
    assign s6_valid_next = load6 || (s6_valid_reg && !out_ready);

    assign span     = katm_pkg::SPAN_BASE + {1'b0, end_cutoff, 1'b0};
    assign map_next = MAP_PROD_W'(in_data.avg) * MAP_PROD_W'(span);
    assign div_prod = DIV_PROD_W'(map_reg) * DIV_PROD_W'(katm_pkg::DIV255_MUL);

    // High limit first, then low limit, so a crossed pair resolves to low
    always_comb
    begin
        thr_raw = $signed({1'b0, quot_reg}) - $signed({3'b000, end_cutoff});
        high_s  = $signed({2'b00, high_limit});
        low_s   = $signed({2'b00, low_limit});
        thr_hi  = (thr_raw > high_s) ? high_s : thr_raw;
        thr_lo  = (thr_hi < low_s) ? low_s : thr_hi;
        thr_next = item5_reg.refresh ? thr_lo[LIMIT_W-1:0] : thr_reg;
        result_next.held_average    = item5_reg.avg;
        result_next.threshold_value = thr_next;
        result_next.updated         = item5_reg.refresh;
        result_next.display_active  = item5_reg.active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            thr_reg      <= '0;
        end
        else
        begin
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
            s6_valid_reg <= s6_valid_next;
            if (load6)
            begin
                thr_reg <= thr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            map_reg   <= map_next;
            item4_reg <= in_data;
        end
        if (load5)
        begin
            quot_reg  <= div_prod[katm_pkg::DIV255_SHIFT +: QUOT_W];
            item5_reg <= item4_reg;
        end
        if (load6)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = s6_valid_reg;
    assign out_data  = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/knob_average_threshold_mapper.sv =====
// ----------------------------------------------------------------------------
// knob_average_threshold_mapper
// Moving average of knob samples with deadband, threshold map and countdown.
// Throughput: one item per cycle, every stage stalls on its own.
// Pipeline: 6 register stages from accept to result (ring, mean product,
// mean and deadband state, span product, divide by 255, clamp and result).
// Reset: registers take their defaults; ring entries read as zero until the
// write pointer first wraps, so no clearing pass is run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module knob_average_threshold_mapper #(
    parameter int unsigned RING_DEPTH = katm_pkg::RING_DEPTH_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    katm_stream_if.sink   sample,
    katm_stream_if.source result,
    katm_stream_if.sink   cfg
);

    localparam int unsigned TOTAL_W = katm_pkg::total_width(RING_DEPTH);
    localparam int unsigned OCC_W   = $clog2(katm_pkg::PIPE_STAGES + 1);

    katm_pkg::cfg_regs_t cfg_reg, cfg_next;

    logic               ring_valid, ring_ready;
    logic [TOTAL_W-1:0] ring_total;
    logic               ring_force;
    logic               mean_valid, mean_ready;
    katm_pkg::mean_item_t mean_item;
    katm_pkg::result_t  result_data;
    logic               result_valid;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.data.reg_index)
                katm_pkg::REG_END_CUTOFF:
                    cfg_next.end_cutoff = cfg.data.reg_value[katm_pkg::CUTOFF_W-1:0];
                katm_pkg::REG_LOW_LIMIT:
                    cfg_next.low_limit = cfg.data.reg_value[katm_pkg::LIMIT_W-1:0];
                katm_pkg::REG_HIGH_LIMIT:
                    cfg_next.high_limit = cfg.data.reg_value[katm_pkg::LIMIT_W-1:0];
                katm_pkg::REG_DEADBAND:
                    cfg_next.deadband = cfg.data.reg_value[katm_pkg::DEADBAND_W-1:0];
                katm_pkg::REG_DISP_TICKS:
                    cfg_next.disp_ticks = cfg.data.reg_value[katm_pkg::TICKS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.end_cutoff <= katm_pkg::END_CUTOFF_RESET;
            cfg_reg.low_limit  <= katm_pkg::LOW_LIMIT_RESET;
            cfg_reg.high_limit <= katm_pkg::HIGH_LIMIT_RESET;
            cfg_reg.deadband   <= katm_pkg::DEADBAND_RESET;
            cfg_reg.disp_ticks <= katm_pkg::DISP_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    katm_ring #(
        .RING_DEPTH (RING_DEPTH),
        .TOTAL_W    (TOTAL_W)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .in_data   (sample.data),
        .out_valid (ring_valid),
        .out_ready (ring_ready),
        .out_total (ring_total),
        .out_force (ring_force)
    );

    katm_refresh #(
        .RING_DEPTH (RING_DEPTH),
        .TOTAL_W    (TOTAL_W)
    ) u_refresh (
        .clk        (clk),
        .rst_n      (rst_n),
        .deadband   (cfg_reg.deadband),
        .disp_ticks (cfg_reg.disp_ticks),
        .in_valid   (ring_valid),
        .in_ready   (ring_ready),
        .in_total   (ring_total),
        .in_force   (ring_force),
        .out_valid  (mean_valid),
        .out_ready  (mean_ready),
        .out_data   (mean_item)
    );

    katm_mapper u_mapper (
        .clk        (clk),
        .rst_n      (rst_n),
        .end_cutoff (cfg_reg.end_cutoff),
        .low_limit  (cfg_reg.low_limit),
        .high_limit (cfg_reg.high_limit),
        .in_valid   (mean_valid),
        .in_ready   (mean_ready),
        .in_data    (mean_item),
        .out_valid  (result_valid),
        .out_ready  (result.ready),
        .out_data   (result_data)
    );

    assign result.valid = result_valid;
    assign result.data  = result_data;

    // Items in flight, for checking only
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             in_fire, out_fire;

    assign in_fire  = sample.valid && sample.ready;
    assign out_fire = result_valid && result.ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_fire && !out_fire)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (out_fire && !in_fire)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg <= OCC_W'(katm_pkg::PIPE_STAGES)) && (result_valid == 1'b0 || occ_reg != '0))
        else $error("pipeline holds more items than stages, or a result with none in flight");

    a_thr_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.updated && (cfg_reg.low_limit <= cfg_reg.high_limit))
        |-> ((result_data.threshold_value >= cfg_reg.low_limit)
             && (result_data.threshold_value <= cfg_reg.high_limit)))
        else $error("refreshed threshold outside the limits");

    a_reload_active: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.updated && (cfg_reg.disp_ticks != '0))
        |-> result_data.display_active)
        else $error("countdown reload did not mark the display active");

endmodule

`default_nettype wire

// ===== tb/katm_result_checker.sv =====
// ----------------------------------------------------------------------------
// katm_result_checker
// Watches the sample, result and register channels of the knob average
// threshold mapper. It keeps its own copy of the ring, the held average,
// the threshold and the display countdown, predicts one result per
// accepted sample and compares each accepted result with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module katm_result_checker
    import katm_pkg::*;
#(
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    input  logic        sample_ready,
    input  sample_t     sample_item,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result_item,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_write_t  cfg_item,
    output int unsigned failures,
    output int unsigned outstanding
);

    localparam int unsigned REPORT_LIMIT = 10;

    // Register copies
    logic [CUTOFF_W-1:0]   cutoff_reg;
    logic [LIMIT_W-1:0]    low_limit_reg;
    logic [LIMIT_W-1:0]    high_limit_reg;
    logic [DEADBAND_W-1:0] deadband_reg;
    logic [TICKS_W-1:0]    ticks_reg;

    // Block state copies
    logic [VAL_W-1:0]   knob_ring [RING_DEPTH];
    int unsigned        ring_slot;
    int unsigned        ring_sum;
    logic [VAL_W-1:0]   held_avg;
    logic [LIMIT_W-1:0] held_threshold;
    logic [TICKS_W-1:0] countdown;

    result_t     expected_results [$];
    result_t     predicted;
    result_t     oldest;
    int unsigned failure_total;

    task automatic note_failure(input string text);
        failure_total++;
        if (failure_total <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $time, text);
        end
    endtask

    task automatic knob_model_step(input sample_t item, output result_t res);
        logic [VAL_W-1:0] reduced;
        logic [VAL_W-1:0] mean;
        logic [VAL_W-1:0] gap;
        logic             refresh;
        logic             active;
        longint           span;
        longint           mapped;
        reduced = VAL_W'(item.knob_sample >> SAMPLE_SHIFT);
        // Replace the oldest ring entry and keep the running sum
        ring_sum = ring_sum - knob_ring[ring_slot] + reduced;
        knob_ring[ring_slot] = reduced;
        ring_slot = (ring_slot + 1) % RING_DEPTH;
        mean = VAL_W'(ring_sum / RING_DEPTH);
        gap = (mean > held_avg) ? mean - held_avg : held_avg - mean;
        refresh = item.force_update || (gap > deadband_reg);
        if (refresh)
        begin
            held_avg = mean;
            span = 65536 + 2 * longint'(cutoff_reg);
            mapped = (longint'(mean) * span) / 255 - longint'(cutoff_reg);
            // High limit first, low limit last so it wins when crossed
            if (mapped > longint'(high_limit_reg))
            begin
                mapped = longint'(high_limit_reg);
            end
            if (mapped < longint'(low_limit_reg))
            begin
                mapped = longint'(low_limit_reg);
            end
            held_threshold = mapped[LIMIT_W-1:0];
            countdown = ticks_reg;
        end
        active = (countdown != '0);
        if (active)
        begin
            countdown = countdown - 1'b1;
        end
        res.held_average    = held_avg;
        res.threshold_value = held_threshold;
        res.updated         = refresh;
        res.display_active  = active;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg     = END_CUTOFF_RESET;
            low_limit_reg  = LOW_LIMIT_RESET;
            high_limit_reg = HIGH_LIMIT_RESET;
            deadband_reg   = DEADBAND_RESET;
            ticks_reg      = DISP_TICKS_RESET;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                knob_ring[i] = '0;
            end
            ring_slot      = 0;
            ring_sum       = 0;
            held_avg       = '0;
            held_threshold = '0;
            countdown      = '0;
            expected_results.delete();
            failure_total  = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_item.reg_index)
                    REG_END_CUTOFF: cutoff_reg     = cfg_item.reg_value[CUTOFF_W-1:0];
                    REG_LOW_LIMIT:  low_limit_reg  = cfg_item.reg_value[LIMIT_W-1:0];
                    REG_HIGH_LIMIT: high_limit_reg = cfg_item.reg_value[LIMIT_W-1:0];
                    REG_DEADBAND:   deadband_reg   = cfg_item.reg_value[DEADBAND_W-1:0];
                    REG_DISP_TICKS: ticks_reg      = cfg_item.reg_value[TICKS_W-1:0];
                    default: ;
                endcase
            end
            if (sample_valid && sample_ready)
            begin
                knob_model_step(sample_item, predicted);
                expected_results.push_back(predicted);
            end
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf("result with none expected: avg %0d thr %0d",
                        result_item.held_average, result_item.threshold_value));
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result_item.held_average !== oldest.held_average
                        || result_item.threshold_value !== oldest.threshold_value
                        || result_item.updated !== oldest.updated
                        || result_item.display_active !== oldest.display_active)
                    begin
                        note_failure($sformatf({"mismatch: avg exp %0d got %0d, ",
                            "thr exp %0d got %0d, upd exp %0b got %0b, ",
                            "active exp %0b got %0b"},
                            oldest.held_average, result_item.held_average,
                            oldest.threshold_value, result_item.threshold_value,
                            oldest.updated, result_item.updated,
                            oldest.display_active, result_item.display_active));
                    end
                end
            end
            failures    <= failure_total;
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/knob_average_threshold_mapper_tb.sv =====
// ----------------------------------------------------------------------------
// knob_average_threshold_mapper_tb
// Drives knob samples and register writes into the mapper with random
// gaps and result stalls, first a directed set around the register
// extremes, then phases of random settings and sample streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module knob_average_threshold_mapper_tb;

    import katm_pkg::*;

    localparam int unsigned PHASES          = 10;
    localparam int unsigned ITEMS_PER_PHASE = 190;
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned DRAIN_CYCLES    = 12;

    // Indexes past the last register
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_A = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_B = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_C = 3'd7;

    logic        clk;
    logic        rst_n;
    bit          calm;
    int          knob_level;
    int unsigned failures;
    int unsigned outstanding;
    int unsigned cycle_count;

    katm_stream_if #(.payload_t(sample_t))    sample_ch ();
    katm_stream_if #(.payload_t(result_t))    result_ch ();
    katm_stream_if #(.payload_t(cfg_write_t)) cfg_ch ();

    knob_average_threshold_mapper DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    katm_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_ch.valid),
        .sample_ready (sample_ch.ready),
        .sample_item  (sample_ch.data),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_item  (result_ch.data),
        .cfg_valid    (cfg_ch.valid),
        .cfg_ready    (cfg_ch.ready),
        .cfg_item     (cfg_ch.data),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Mostly short gaps, a few long ones, none in calm phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        forever
        begin
            int run;
            int g;
            run = $urandom_range(1, 8);
            result_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            g = pick_gap();
            if (g > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    task automatic send_knob(input logic [SAMPLE_W-1:0] knob, input logic force_it);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= sample_t'{knob_sample: knob, force_update: force_it};
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_VALUE_W-1:0] value);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            cfg_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cfg_write_t'{reg_index: idx, reg_value: value};
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    // Drop both valids and hold until every predicted result has come back
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    function automatic logic [CFG_VALUE_W-1:0] random_reg_value(
        input logic [CFG_INDEX_W-1:0] idx);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            return CFG_VALUE_W'($urandom);
        end
        case (idx)
            REG_END_CUTOFF:
            begin
                if (mode == 1) return '0;
                if (mode == 2) return CFG_VALUE_W'(32768);
                return CFG_VALUE_W'($urandom_range(0, 32768));
            end
            REG_LOW_LIMIT, REG_HIGH_LIMIT:
            begin
                if (mode == 1) return '0;
                if (mode == 2) return CFG_VALUE_W'(65536);
                return CFG_VALUE_W'($urandom_range(0, 65536));
            end
            REG_DEADBAND:
            begin
                if (mode == 1) return '0;
                if (mode == 2) return CFG_VALUE_W'(255);
                if (mode < 6) return CFG_VALUE_W'($urandom_range(0, 16));
                return CFG_VALUE_W'($urandom_range(0, 255));
            end
            REG_DISP_TICKS:
            begin
                if (mode == 1) return '0;
                if (mode == 2) return CFG_VALUE_W'(65535);
                return CFG_VALUE_W'($urandom_range(0, 40));
            end
            default: return CFG_VALUE_W'($urandom);
        endcase
    endfunction

    // Slow knob walks mixed with jumps, rail values and steady runs
    task automatic send_random_knob();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 50)
        begin
            knob_level = knob_level + $urandom_range(0, 96) - 48;
            if (knob_level < 0) knob_level = 0;
            if (knob_level > 4095) knob_level = 4095;
        end
        else if (mode < 80)
        begin
            knob_level = $urandom_range(0, 4095);
        end
        else if (mode < 90)
        begin
            knob_level = ($urandom_range(0, 1) != 0) ? 4095 : 0;
        end
        send_knob(knob_level[SAMPLE_W-1:0], $urandom_range(0, 99) < 15);
    endtask

    initial
    begin
        sample_ch.valid <= 1'b0;
        sample_ch.data  <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= '0;
        rst_n = 1'b0;
        knob_level = 0;
        calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: negative mapping at zero, partial ring fill, bit patterns
        send_knob(12'h000, 1'b1);
        repeat (4) send_knob(12'hFFF, 1'b0);
        send_knob(12'hAAA, 1'b0);
        send_knob(12'h555, 1'b1);
        send_knob(12'h00F, 1'b0);
        send_knob(12'hFF0, 1'b0);
        wait_drained();

        // Oversized values, crossed limits, zero deadband, zero reload
        write_reg(REG_END_CUTOFF, 17'h1FFFF);
        write_reg(REG_LOW_LIMIT, 17'd65536);
        write_reg(REG_HIGH_LIMIT, 17'd0);
        write_reg(REG_DEADBAND, 17'h1FF00);
        write_reg(REG_DISP_TICKS, 17'd0);
        write_reg(REG_UNMAPPED_A, 17'h1FFFF);
        write_reg(REG_UNMAPPED_B, 17'h1FFFF);
        write_reg(REG_UNMAPPED_C, 17'h1FFFF);
        wait_drained();
        send_knob(12'hFFF, 1'b1);
        send_knob(12'h000, 1'b0);
        send_knob(12'h800, 1'b0);
        send_knob(12'hFFF, 1'b0);
        wait_drained();

        // Widest cutoff, full limits, widest deadband, one tick
        write_reg(REG_END_CUTOFF, 17'd32768);
        write_reg(REG_LOW_LIMIT, 17'd0);
        write_reg(REG_HIGH_LIMIT, 17'd65536);
        write_reg(REG_DEADBAND, 17'd255);
        write_reg(REG_DISP_TICKS, 17'd1);
        wait_drained();
        send_knob(12'h000, 1'b1);
        repeat (3) send_knob(12'hFFF, 1'b0);
        send_knob(12'hFFF, 1'b1);
        send_knob(12'h800, 1'b0);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p % 3 == 1);
            write_reg(REG_END_CUTOFF, random_reg_value(REG_END_CUTOFF));
            write_reg(REG_LOW_LIMIT, random_reg_value(REG_LOW_LIMIT));
            write_reg(REG_HIGH_LIMIT, random_reg_value(REG_HIGH_LIMIT));
            write_reg(REG_DEADBAND, random_reg_value(REG_DEADBAND));
            write_reg(REG_DISP_TICKS, random_reg_value(REG_DISP_TICKS));
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_UNMAPPED_A + CFG_INDEX_W'($urandom_range(0, 2)),
                          CFG_VALUE_W'($urandom));
            end
            wait_drained();
            repeat (ITEMS_PER_PHASE) send_random_knob();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
